[rtl/integer_to_ascii_formatter_top_defines.svh]
// assertion macros for the integer to ascii formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define ITOA_ASSERT_ALWAYS(name, clock, resetn, expr) \
    name: assert property (@(posedge clock) disable iff (!resetn) (expr)) \
        else $error("itoa assertion failed");

`define ITOA_ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("itoa assertion failed");

`else

`define ITOA_ASSERT_ALWAYS(name, clock, resetn, expr)

`define ITOA_ASSERT_NEXT(name, clock, resetn, ante, cons)

`endif

`endif

[rtl/itoa_pkg.sv]
// shared constants, types and functions of the integer to ascii formatter
`default_nettype none

package itoa_pkg;

    localparam int ValueWidth    = 32;
    localparam int NarrowWidth   = 16;
    localparam int ModeWidth     = 2;
    localparam int DigitWidth    = 4;
    localparam int DigitShift    = $clog2(DigitWidth);
    localparam int MaxDigits     = 10;
    localparam int BcdWidth      = DigitWidth * MaxDigits;
    localparam int DigitCntWidth = $clog2(MaxDigits + 1);
    localparam int MaxChars      = MaxDigits + 1;
    localparam int CountWidth    = $clog2(MaxChars + 1);
    localparam int CharWidth     = 8;
    localparam int StepsPerStage = 4;
    localparam int DabbleStages  = ValueWidth / StepsPerStage;

    localparam logic [ModeWidth-1:0] MODE_UDEC = 2'd0;
    localparam logic [ModeWidth-1:0] MODE_SDEC = 2'd1;
    localparam logic [ModeWidth-1:0] MODE_HEX  = 2'd2;
    localparam int ModeHexBit = 1;

    localparam logic [CharWidth-1:0] ZeroChar  = 8'h30;
    localparam logic [CharWidth-1:0] UpperA    = 8'h41;
    localparam logic [CharWidth-1:0] LowerA    = 8'h61;
    localparam logic [CharWidth-1:0] MinusChar = 8'h2d;
    localparam logic [CharWidth-1:0] PadChar   = 8'h00;

    typedef struct packed {
        logic [BcdWidth-1:0]   bcd;
        logic [ValueWidth-1:0] bin;
        logic [ValueWidth-1:0] raw;
        logic                  neg;
        logic                  hex;
        logic                  upper;
    } dabble_t;

    typedef logic [MaxChars-1:0][CharWidth-1:0] text_t;

    typedef struct packed {
        text_t                 text;
        logic [CountWidth-1:0] count;
    } pack_t;

    function automatic logic [CharWidth-1:0] digit_char(
        input logic [DigitWidth-1:0] d,
        input logic                  upper
    );
        logic [CharWidth-1:0] base;
        base = upper ? UpperA : LowerA;
        if (d < DigitWidth'(10))
            return ZeroChar + CharWidth'(d);
        else
            return base + CharWidth'(d) - CharWidth'(10);
    endfunction

endpackage

`default_nettype wire

[rtl/itoa_prep.sv]
// input stage: masks the value, takes the magnitude and decodes the mode
`default_nettype none

module itoa_prep
    import itoa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [ModeWidth-1:0]  mode,
    input  wire logic                  wide,
    input  wire logic                  upper_case,
    input  wire logic [ValueWidth-1:0] value,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output dabble_t                    out_data
);

    logic    valid_reg;
    dabble_t data_reg;
    dabble_t data_next;

    logic [ValueWidth-1:0] masked;
    logic [ValueWidth-1:0] negated;
    logic                  sign;
    logic                  neg;

    always_comb
    begin
        masked  = wide ? value : {{(ValueWidth-NarrowWidth){1'b0}}, value[NarrowWidth-1:0]};
        sign    = wide ? value[ValueWidth-1] : value[NarrowWidth-1];
        neg     = (mode == MODE_SDEC) && sign;
        negated = ValueWidth'(0) - masked;
        if (!wide)
            negated = {{(ValueWidth-NarrowWidth){1'b0}}, negated[NarrowWidth-1:0]};
        data_next.bcd   = '0;
        data_next.bin   = neg ? negated : masked;
        data_next.raw   = masked;
        data_next.neg   = neg;
        data_next.hex   = mode[ModeHexBit];
        data_next.upper = upper_case;
    end

    assign in_stall = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[rtl/itoa_dabble_stage.sv]
// one pipeline stage of the shift-and-add-3 binary to bcd conversion
`default_nettype none

module itoa_dabble_stage
    import itoa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire dabble_t in_data,
    output logic         out_valid,
    input  wire logic    out_stall,
    output dabble_t      out_data
);

    logic    valid_reg;
    dabble_t data_reg;
    dabble_t data_next;

    always_comb
    begin
        data_next = in_data;
        for (int s = 0; s < StepsPerStage; s++)
        begin
            for (int d = 0; d < MaxDigits; d++)
            begin
                if (data_next.bcd[d*DigitWidth +: DigitWidth] >= DigitWidth'(5))
                    data_next.bcd[d*DigitWidth +: DigitWidth] =
                        data_next.bcd[d*DigitWidth +: DigitWidth] + DigitWidth'(3);
            end
            data_next.bcd = {data_next.bcd[BcdWidth-2:0], data_next.bin[ValueWidth-1]};
            data_next.bin = {data_next.bin[ValueWidth-2:0], 1'b0};
        end
    end

    assign in_stall = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[rtl/itoa_pack.sv]
// pack stage: drops leading zeros and builds the character string
`default_nettype none

module itoa_pack
    import itoa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire dabble_t in_data,
    output logic         out_valid,
    input  wire logic    out_stall,
    output pack_t        out_data
);

    logic  valid_reg;
    pack_t data_reg;
    pack_t data_next;

    logic [BcdWidth-1:0]      digits;
    logic [BcdWidth-1:0]      aligned;
    logic [DigitCntWidth-1:0] ndig;
    logic [MaxDigits-1:0][CharWidth-1:0] chars;

    always_comb
    begin
        digits = in_data.hex ? {{(BcdWidth-ValueWidth){1'b0}}, in_data.raw} : in_data.bcd;
        ndig   = DigitCntWidth'(1);
        for (int i = 0; i < MaxDigits; i++)
        begin
            if (digits[i*DigitWidth +: DigitWidth] != '0)
                ndig = DigitCntWidth'(i + 1);
        end
        aligned = digits << {DigitCntWidth'(MaxDigits) - ndig, {DigitShift{1'b0}}};
        for (int j = 0; j < MaxDigits; j++)
            chars[j] = digit_char(aligned[BcdWidth-1-DigitWidth*j -: DigitWidth], in_data.upper);
        if (in_data.neg)
        begin
            data_next.text[0] = MinusChar;
            for (int j = 0; j < MaxDigits; j++)
                data_next.text[j+1] = chars[j];
        end
        else
        begin
            for (int j = 0; j < MaxDigits; j++)
                data_next.text[j] = chars[j];
            data_next.text[MaxChars-1] = PadChar;
        end
        data_next.count = CountWidth'(ndig) + CountWidth'(in_data.neg);
    end

    assign in_stall = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[rtl/itoa_serial.sv]
// output stage: shifts the string out one character per transaction
`default_nettype none

`include "integer_to_ascii_formatter_top_defines.svh"

module itoa_serial
    import itoa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire pack_t                 in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [CharWidth-1:0]       character,
    output logic                       last
);

    logic                  valid_reg;
    logic [CountWidth-1:0] left_reg;
    text_t                 text_reg;
    logic                  final_char;
    logic                  out_take;
    logic                  in_take;

    assign final_char = (left_reg == CountWidth'(1));
    assign out_take   = valid_reg && !out_stall;
    assign in_stall   = valid_reg && !(out_take && final_char);
    assign in_take    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end
        else if (in_take)
        begin
            valid_reg <= 1'b1;
            left_reg  <= in_data.count;
        end
        else if (out_take)
        begin
            valid_reg <= !final_char;
            left_reg  <= left_reg - CountWidth'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            text_reg <= in_data.text;
        else if (out_take)
            text_reg <= text_reg >> CharWidth;
    end

    assign out_valid = valid_reg;
    assign character = text_reg[0];
    assign last      = final_char;

    `ITOA_ASSERT_ALWAYS(a_count_range, clk, rst_n, !valid_reg || (left_reg != '0 && left_reg <= CountWidth'(MaxChars)))
    `ITOA_ASSERT_NEXT(a_count_down, clk, rst_n, out_take && !final_char, valid_reg && left_reg == $past(left_reg) - CountWidth'(1))
    `ITOA_ASSERT_NEXT(a_load_count, clk, rst_n, in_take, valid_reg && left_reg == $past(in_data.count))

endmodule

`default_nettype wire

[rtl/integer_to_ascii_formatter_top.sv]
// integer to ascii formatter: prep, bcd conversion pipeline, pack and serializer
// usage:
//   input channel in_valid/in_stall carries mode, wide, upper_case and value;
//   a transaction is taken when in_valid is high and in_stall is low
//   output channel out_valid/out_stall carries one ascii character per
//   transaction, with last high on the final character of each number
//   the first character of a number passes the registers of one prep
//   stage, eight bcd stages of four shift steps each, one pack stage and one
//   output register, in that order, before it is presented
//   each number takes as many output transactions as its character count
//   (1 to 11), set by the single character output port; the pipeline keeps
//   taking numbers while earlier ones are being converted
//   reset clears all valid bits; no character is pending afterwards
//   when the receiver raises out_stall the current character holds and the
//   stall backs up stage by stage without losing or repeating a transaction
`default_nettype none

module integer_to_ascii_formatter_top
    import itoa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [ModeWidth-1:0]  mode,
    input  wire logic                  wide,
    input  wire logic                  upper_case,
    input  wire logic [ValueWidth-1:0] value,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [CharWidth-1:0]       character,
    output logic                       last
);

    dabble_t               stage_data  [DabbleStages+1];
    logic [DabbleStages:0] stage_valid;
    logic [DabbleStages:0] stage_stall;
    logic                  pack_valid;
    logic                  pack_stall;
    pack_t                 pack_data;

    itoa_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .wide       (wide),
        .upper_case (upper_case),
        .value      (value),
        .out_valid  (stage_valid[0]),
        .out_stall  (stage_stall[0]),
        .out_data   (stage_data[0])
    );

    for (genvar g = 0; g < DabbleStages; g++)
    begin : g_dabble
        itoa_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[g]),
            .in_stall  (stage_stall[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_stall (stage_stall[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    itoa_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[DabbleStages]),
        .in_stall  (stage_stall[DabbleStages]),
        .in_data   (stage_data[DabbleStages]),
        .out_valid (pack_valid),
        .out_stall (pack_stall),
        .out_data  (pack_data)
    );

    itoa_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pack_valid),
        .in_stall  (pack_stall),
        .in_data   (pack_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

endmodule

`default_nettype wire
